FILE: design/irpv_pkg.sv
// Shared types, constants and helper functions for the IR pulse packet receiver.
package irpv_pkg;

    localparam int MAX_COPIES = 8;
    localparam int MAX_BITS   = 64;

    localparam int WIDTH_W  = 16;
    localparam int COPY_W   = 4;
    localparam int BITS_W   = 7;
    localparam int TALLY_W  = 4;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IDX_W    = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_THRESHOLD    = 3'd0,
        CFG_HEADER_THRESHOLD = 3'd1,
        CFG_GAP_THRESHOLD    = 3'd2,
        CFG_COPY_COUNT       = 3'd3,
        CFG_BITS_PER_COPY    = 3'd4
    } t_cfg_index;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_READ_TIMEOUT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_GAP_TIMEOUT  = 2'd2;

    // Receiver phase, one-hot.
    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_READ = 3'b010,
        PH_GAP  = 3'b100
    } t_phase;

    // Commands from the sequencer to the tally cells.
    typedef struct packed {
        logic             clear;
        logic             inc;
        logic [IDX_W-1:0] idx;
    } t_tally_ctl;

    // Copy count clamped to the range 1 .. MAX_COPIES.
    function automatic logic [COPY_W-1:0] eff_copies(input logic [COPY_W-1:0] cnt);
        logic [COPY_W-1:0] r;
        if (cnt == '0) begin
            r = COPY_W'(1);
        end else if (cnt > COPY_W'(MAX_COPIES)) begin
            r = COPY_W'(MAX_COPIES);
        end else begin
            r = cnt;
        end
        return r;
    endfunction

    // Bits per copy clamped to the range 1 .. MAX_BITS.
    function automatic logic [BITS_W-1:0] eff_bits(input logic [BITS_W-1:0] cnt);
        logic [BITS_W-1:0] r;
        if (cnt == '0) begin
            r = BITS_W'(1);
        end else if (cnt > BITS_W'(MAX_BITS)) begin
            r = BITS_W'(MAX_BITS);
        end else begin
            r = cnt;
        end
        return r;
    endfunction

endpackage

FILE: design/irpv_tally.sv
// Per-bit ones tallies and the bitwise majority vote over all copies.
module irpv_tally (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  irpv_pkg::t_tally_ctl        i_ctl,
    input  logic [irpv_pkg::BITS_W-1:0] i_bits,
    input  logic [irpv_pkg::COPY_W-1:0] i_copies,
    output logic [irpv_pkg::DATA_W-1:0] o_word
);
    import irpv_pkg::*;

    logic [TALLY_W-1:0] r_tally [MAX_BITS];
    logic [MAX_BITS-1:0] w_vote;
    logic [DATA_W-1:0]   w_rev;
    logic [BITS_W-1:0]   w_shift;

    // One cell per bit position; each cell only looks at its own position.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_BITS; i++) begin
            if (!i_rst_n || i_ctl.clear) begin
                r_tally[i] <= '0;
            end else if (i_ctl.inc && (i_ctl.idx == IDX_W'(i))) begin
                r_tally[i] <= r_tally[i] + TALLY_W'(1);
            end
        end
    end

    // A position votes 1 when at least half the copies had a 1 there.
    always_comb begin
        w_rev = '0;
        for (int p = 0; p < MAX_BITS; p++) begin
            w_vote[p] = ({r_tally[p], 1'b0} >= {1'b0, i_copies});
        end
        for (int p = 0; p < MAX_BITS; p++) begin
            w_rev[DATA_W-1-p] = w_vote[p];
        end
    end

    // The first bit received lands at bit (bits - 1) of the word.
    assign w_shift = BITS_W'(DATA_W) - i_bits;
    assign o_word  = w_rev >> w_shift;

endmodule

FILE: design/ir_pulse_packet_receiver_vote.sv
// Top level of the IR pulse packet receiver with majority voting over copies.
//
// The block takes one measured infrared pulse width per input transaction, or
// a timeout mark, and decodes repeated packet copies. It hunts for a header
// pulse at least header_threshold long, then reads bits_per_copy data bits,
// most significant first, where a pulse at or above one_threshold is a one.
// After each copy it waits for a pulse at least gap_threshold long. When
// copy_count gaps have been seen it sends one output transaction holding the
// bitwise majority of all copies (a tie votes one) with status 0. A timeout
// while reading bits or while waiting for a gap sends a zero word with status
// 1 or 2 and goes back to hunting; a timeout while hunting is ignored. The
// block takes one transaction per cycle while its input is not stalled: the
// phase, bit position and copy counters and the 64 per-bit tally cells update
// at the accepting edge, and any result is written on that same edge into the
// output register, or into the one-entry skid register behind it while the
// output register is held, so the block keeps accepting input while a result
// waits; the input stall is raised only when both hold a result. The user must
// write configuration registers through the plain write port while the block
// is idle (not enforced); they take effect on the next input transaction.
module ir_pulse_packet_receiver_vote (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [irpv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [irpv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input pulse channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [irpv_pkg::WIDTH_W-1:0]    i_width,
    input  logic                            i_timed_out,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [irpv_pkg::DATA_W-1:0]     o_packet_data,
    output logic [irpv_pkg::STATUS_W-1:0]   o_status
);
    import irpv_pkg::*;

    // Configuration registers.
    logic [WIDTH_W-1:0] r_one_thr;
    logic [WIDTH_W-1:0] r_hdr_thr;
    logic [WIDTH_W-1:0] r_gap_thr;
    logic [COPY_W-1:0]  r_copy_count;
    logic [BITS_W-1:0]  r_bits_per_copy;

    // Sequencer state.
    t_phase             r_phase,    n_phase;
    logic [BITS_W-1:0]  r_bit_pos,  n_bit_pos;
    logic [COPY_W-1:0]  r_copies,   n_copies;

    // Output register and skid register.
    logic                r_out_valid,  n_out_valid;
    logic [DATA_W-1:0]   r_out_data,   n_out_data;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic                r_skid_valid,  n_skid_valid;
    logic [DATA_W-1:0]   r_skid_data,   n_skid_data;
    logic [STATUS_W-1:0] r_skid_status, n_skid_status;

    logic                w_in_acc;
    logic [BITS_W-1:0]   w_nb;
    logic [COPY_W-1:0]   w_nc;
    logic [BITS_W-1:0]   w_bp_step;
    logic [COPY_W-1:0]   w_copies_inc;
    logic [DATA_W-1:0]   w_vote_word;
    t_tally_ctl          w_tally_ctl;
    logic                w_res_valid;
    logic [DATA_W-1:0]   w_res_data;
    logic [STATUS_W-1:0] w_res_status;

    assign w_in_acc = i_in_valid && !r_skid_valid;
    assign w_nb     = eff_bits(r_bits_per_copy);
    assign w_nc     = eff_copies(r_copy_count);

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_thr       <= WIDTH_W'(1000);
            r_hdr_thr       <= WIDTH_W'(4000);
            r_gap_thr       <= WIDTH_W'(8000);
            r_copy_count    <= COPY_W'(3);
            r_bits_per_copy <= BITS_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ONE_THRESHOLD:    r_one_thr       <= i_cfg_data;
                CFG_HEADER_THRESHOLD: r_hdr_thr       <= i_cfg_data;
                CFG_GAP_THRESHOLD:    r_gap_thr       <= i_cfg_data;
                CFG_COPY_COUNT:       r_copy_count    <= i_cfg_data[COPY_W-1:0];
                CFG_BITS_PER_COPY:    r_bits_per_copy <= i_cfg_data[BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // The bit position only advances while it is inside the current bit count,
    // so a bit count lowered mid-packet ends the copy at once.
    assign w_bp_step    = (r_bit_pos < w_nb) ? (r_bit_pos + BITS_W'(1)) : r_bit_pos;
    assign w_copies_inc = r_copies + COPY_W'(1);

    // Sequencer: one input transaction is fully handled in this cycle.
    always_comb begin
        n_phase      = r_phase;
        n_bit_pos    = r_bit_pos;
        n_copies     = r_copies;
        w_tally_ctl  = '0;
        w_res_valid  = 1'b0;
        w_res_data   = '0;
        w_res_status = ST_OK;
        if (w_in_acc) begin
            unique case (r_phase)
                PH_READ: begin
                    if (i_timed_out) begin
                        w_res_valid  = 1'b1;
                        w_res_status = ST_READ_TIMEOUT;
                        n_phase      = PH_HUNT;
                    end else begin
                        w_tally_ctl.inc = (r_bit_pos < w_nb) && (i_width >= r_one_thr);
                        w_tally_ctl.idx = r_bit_pos[IDX_W-1:0];
                        if (w_bp_step >= w_nb) begin
                            n_bit_pos = '0;
                            n_phase   = PH_GAP;
                        end else begin
                            n_bit_pos = w_bp_step;
                        end
                    end
                end
                PH_GAP: begin
                    if (i_timed_out) begin
                        w_res_valid  = 1'b1;
                        w_res_status = ST_GAP_TIMEOUT;
                        n_phase      = PH_HUNT;
                    end else if (i_width >= r_gap_thr) begin
                        n_copies = w_copies_inc;
                        if (w_copies_inc >= w_nc) begin
                            w_res_valid = 1'b1;
                            w_res_data  = w_vote_word;
                            n_phase     = PH_HUNT;
                        end else begin
                            n_phase = PH_READ;
                        end
                    end
                end
                default: begin
                    // Header hunt; any stray phase code behaves the same way.
                    n_phase = PH_HUNT;
                    if (!i_timed_out && (i_width >= r_hdr_thr)) begin
                        w_tally_ctl.clear = 1'b1;
                        n_bit_pos         = '0;
                        n_copies          = '0;
                        n_phase           = PH_READ;
                    end
                end
            endcase
        end
    end

    // Output register with a skid register behind it. The skid register only
    // fills when a new result arrives while the output register is held.
    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;
        n_out_status  = r_out_status;
        n_skid_valid  = r_skid_valid;
        n_skid_data   = r_skid_data;
        n_skid_status = r_skid_status;
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_out_status = r_skid_status;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid  = w_res_valid;
                n_out_data   = w_res_data;
                n_out_status = w_res_status;
            end
        end else if (w_res_valid) begin
            n_skid_valid  = 1'b1;
            n_skid_data   = w_res_data;
            n_skid_status = w_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_bit_pos    <= '0;
            r_copies     <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bit_pos    <= n_bit_pos;
            r_copies     <= n_copies;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data    <= n_out_data;
        r_out_status  <= n_out_status;
        r_skid_data   <= n_skid_data;
        r_skid_status <= n_skid_status;
    end

    irpv_tally u_tally (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_tally_ctl),
        .i_bits   (w_nb),
        .i_copies (w_nc),
        .o_word   (w_vote_word)
    );

    assign o_in_stall    = r_skid_valid;
    assign o_out_valid   = r_out_valid;
    assign o_packet_data = r_out_data;
    assign o_status      = r_out_status;

endmodule

FILE: design/irpv_checker.sv
// Port-level checker for the IR pulse packet receiver, bound to the top level.
module irpv_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [irpv_pkg::DATA_W-1:0]     o_packet_data,
    input logic [irpv_pkg::STATUS_W-1:0]   o_status
);
    import irpv_pkg::*;

    // Error results always carry a zero word.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_packet_data == '0))
        else $error("error result with nonzero packet data");

    // A held result stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_packet_data) && $stable(o_status)))
        else $error("stalled result changed");

    // Input is only stalled while a result is waiting at the output.
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");

    // The input stall only comes up after the output was held the cycle before.
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall rose without a held result");

endmodule

bind ir_pulse_packet_receiver_vote irpv_checker u_irpv_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench for the IR pulse packet receiver with majority voting.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import irpv_pkg::*;

    // Cycles without any accepted transaction before the run is abandoned. The
    // longest quiet stretch of a correct run is the deliberate output hold-off.
    localparam int STUCK_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    // A result is registered on the edge that takes its transaction; the drain wait
    // covers any pulse still being absorbed when the last result shows up.
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic               timed_out;
    } t_pulse;

    typedef struct packed {
        logic [DATA_W-1:0]   word;
        logic [STATUS_W-1:0] status;
    } t_vote;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [WIDTH_W-1:0]    i_width     = '0;
    logic                  i_timed_out = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [DATA_W-1:0]     o_packet_data;
    logic [STATUS_W-1:0]   o_status;

    // Receiver model: register copies and decoding state.
    logic [WIDTH_W-1:0] one_thr    = 16'd1000;
    logic [WIDTH_W-1:0] header_thr = 16'd4000;
    logic [WIDTH_W-1:0] gap_thr    = 16'd8000;
    logic [COPY_W-1:0]  copy_cfg   = 4'd3;
    logic [BITS_W-1:0]  bit_cfg    = 7'd32;
    t_phase             rx_phase   = PH_HUNT;
    logic [BITS_W-1:0]  bit_idx    = '0;
    logic [COPY_W-1:0]  copies_seen = '0;
    logic [TALLY_W-1:0] ones_count [MAX_BITS];

    t_pulse pulse_queue [$];   // pulses waiting to be offered
    t_vote  vote_queue [$];    // results the receiver owes us, oldest first
    t_pulse offered;
    t_vote  want;

    int  queued_items  = 0;
    int  errors        = 0;
    int  stuck_cycles  = 0;
    int  send_idle_pct = 16;
    int  recv_idle_pct = 69;
    int  hold_left     = 0;
    bit  hold_armed    = 1'b0;
    bit  hold_done     = 1'b0;

    ir_pulse_packet_receiver_vote u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_width       (i_width),
        .i_timed_out   (i_timed_out),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_packet_data (o_packet_data),
        .o_status      (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // A zero count means one; anything above the hardware maximum means the maximum.
    function automatic int clamp_count(input int value, input int limit);
        if (value == 0) return 1;
        if (value > limit) return limit;
        return value;
    endfunction

    // Advances the receiver model by one accepted pulse and records any result.
    function automatic void decode_pulse(input t_pulse p);
        int    nbits;
        int    ncopies;
        t_vote v;
        nbits   = clamp_count(int'(bit_cfg), MAX_BITS);
        ncopies = clamp_count(int'(copy_cfg), MAX_COPIES);
        v = '0;
        case (rx_phase)
            PH_READ: begin
                if (p.timed_out) begin
                    v.status = ST_READ_TIMEOUT;
                    vote_queue.push_back(v);
                    rx_phase = PH_HUNT;
                end else begin
                    // A bit position already past the count (the count shrank
                    // mid-copy) takes no tally and closes the copy at once.
                    if (int'(bit_idx) < nbits) begin
                        if (p.width >= one_thr) begin
                            ones_count[bit_idx] = ones_count[bit_idx] + 1'b1;
                        end
                        bit_idx = bit_idx + 1'b1;
                    end
                    if (int'(bit_idx) >= nbits) begin
                        bit_idx  = '0;
                        rx_phase = PH_GAP;
                    end
                end
            end
            PH_GAP: begin
                if (p.timed_out) begin
                    v.status = ST_GAP_TIMEOUT;
                    vote_queue.push_back(v);
                    rx_phase = PH_HUNT;
                end else if (p.width >= gap_thr) begin
                    copies_seen = copies_seen + 1'b1;
                    if (int'(copies_seen) >= ncopies) begin
                        // First bit received lands in the top used bit; a tie votes one.
                        for (int i = 0; i < nbits; i++) begin
                            if (2 * int'(ones_count[i]) >= ncopies) v.word[nbits-1-i] = 1'b1;
                        end
                        v.status = ST_OK;
                        vote_queue.push_back(v);
                        rx_phase = PH_HUNT;
                    end else begin
                        rx_phase = PH_READ;
                    end
                end
            end
            default: begin
                rx_phase = PH_HUNT;
                if (!p.timed_out && p.width >= header_thr) begin
                    foreach (ones_count[i]) ones_count[i] = '0;
                    bit_idx     = '0;
                    copies_seen = '0;
                    rx_phase    = PH_READ;
                end
            end
        endcase
    endfunction

    function automatic logic [WIDTH_W-1:0] width_at_least(input logic [WIDTH_W-1:0] thr);
        return WIDTH_W'($urandom_range(32'hFFFF, int'(thr)));
    endfunction

    function automatic logic [WIDTH_W-1:0] width_below(input logic [WIDTH_W-1:0] thr);
        return (thr == '0) ? '0 : WIDTH_W'($urandom_range(int'(thr) - 1, 0));
    endfunction

    // Pulses the receiver simply ignores are not counted toward the run length.
    function automatic void queue_pulse(input logic [WIDTH_W-1:0] w, input logic t,
                                        input bit counted);
        t_pulse p;
        p.width     = w;
        p.timed_out = t;
        pulse_queue.push_back(p);
        if (counted) queued_items++;
    endfunction

    // One packet under the current settings: a header, then every copy's bits and
    // gap. Copies are noisy versions of one word so the vote has work to do. Now
    // and then the packet is cut short by a timeout while reading or in the gap.
    function automatic void queue_packet();
        int                nbits;
        int                ncopies;
        logic [DATA_W-1:0] base;
        logic              bit_one;
        nbits   = clamp_count(int'(bit_cfg), MAX_BITS);
        ncopies = clamp_count(int'(copy_cfg), MAX_COPIES);
        base    = {$urandom, $urandom};
        if ($urandom_range(7) == 0) begin
            if ($urandom_range(1) == 0) begin
                queue_pulse(WIDTH_W'($urandom), 1'b1, 1'b0);
            end else if (header_thr != '0) begin
                queue_pulse(width_below(header_thr), 1'b0, 1'b0);
            end
        end
        queue_pulse(width_at_least(header_thr), 1'b0, 1'b1);
        for (int c = 0; c < ncopies; c++) begin
            for (int b = 0; b < nbits; b++) begin
                if ($urandom_range(255) == 0) begin
                    queue_pulse(WIDTH_W'($urandom), 1'b1, 1'b1);
                    return;
                end
                bit_one = base[b] ^ ($urandom_range(3) == 0);
                queue_pulse(bit_one ? width_at_least(one_thr) : width_below(one_thr),
                            1'b0, 1'b1);
            end
            if (gap_thr != '0 && $urandom_range(3) == 0) begin
                queue_pulse(width_below(gap_thr), 1'b0, 1'b0);
            end
            if ($urandom_range(31) == 0) begin
                queue_pulse(WIDTH_W'($urandom), 1'b1, 1'b1);
                return;
            end
            queue_pulse(width_at_least(gap_thr), 1'b0, 1'b1);
        end
    endfunction

    // Waits until every pulse is taken and every result has come back.
    task automatic wait_drained();
        while (pulse_queue.size() != 0 || i_in_valid || vote_queue.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Registers are only written while the receiver is idle, so the model copy
    // can change at the same moment.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_ONE_THRESHOLD:    one_thr    = data;
            CFG_HEADER_THRESHOLD: header_thr = data;
            CFG_GAP_THRESHOLD:    gap_thr    = data;
            CFG_COPY_COUNT:       copy_cfg   = data[COPY_W-1:0];
            CFG_BITS_PER_COPY:    bit_cfg    = data[BITS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // The narrow registers get random upper data bits, which must be dropped.
    task automatic set_config(input int one_level, input int header_level,
                              input int gap_level, input int copy_total,
                              input int bit_total);
        write_reg(CFG_ONE_THRESHOLD, CFG_DATA_W'(one_level));
        write_reg(CFG_HEADER_THRESHOLD, CFG_DATA_W'(header_level));
        write_reg(CFG_GAP_THRESHOLD, CFG_DATA_W'(gap_level));
        write_reg(CFG_COPY_COUNT,
                  {(CFG_DATA_W-COPY_W)'($urandom), COPY_W'(copy_total)});
        write_reg(CFG_BITS_PER_COPY,
                  {(CFG_DATA_W-BITS_W)'($urandom), BITS_W'(bit_total)});
    endtask

    // Mostly whole packets, with about one stray pulse in ten.
    task automatic run_phase(input int count);
        int first;
        first = queued_items;
        while (queued_items - first < count) begin
            if ($urandom_range(9) == 0) begin
                queue_pulse(WIDTH_W'($urandom), $urandom_range(3) == 0, 1'b0);
            end else begin
                queue_packet();
            end
        end
        wait_drained();
    endtask

    // Input side. A pulse is taken on an edge where valid is high and stall low;
    // the model is advanced right there. A stalled pulse is held unchanged.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                decode_pulse(offered);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pulse_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pulse_queue.pop_front();
                    i_in_valid  <= 1'b1;
                    i_width     <= offered.width;
                    i_timed_out <= offered.timed_out;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side. Every accepted result transaction is compared with the oldest
    // owed one. Once armed, the stall is held for a long stretch so that the
    // output and skid registers fill and the receiver must stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (vote_queue.size() == 0) begin
                    $display("%0t: result with none owed: word %h status %0d",
                             $time, o_packet_data, o_status);
                    errors++;
                end else begin
                    want = vote_queue.pop_front();
                    if (o_packet_data !== want.word) begin
                        $display("%0t: packet_data expected %h got %h",
                                 $time, want.word, o_packet_data);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, o_status);
                        errors++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_armed && !hold_done) begin
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog: too long without any transaction on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        foreach (ones_count[i]) ones_count[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: a timeout and a short pulse are ignored while hunting,
        // a header exactly at threshold starts a packet, a timeout ends it.
        queue_pulse(16'hFFFF, 1'b1, 1'b1);
        queue_pulse(16'd3999, 1'b0, 1'b1);
        queue_pulse(16'd4000, 1'b0, 1'b1);
        queue_pulse(16'd0, 1'b1, 1'b1);
        wait_drained();

        // Two bits, three copies: thresholds hit exactly and missed by one, a short
        // pulse ignored in the gap, then a vote of 2'b10. After that a gap timeout.
        write_reg(CFG_BITS_PER_COPY, 16'd2);
        queue_pulse(16'hFFFF, 1'b0, 1'b1);
        queue_pulse(16'd1000, 1'b0, 1'b1);
        queue_pulse(16'd999, 1'b0, 1'b1);
        queue_pulse(16'd7999, 1'b0, 1'b1);
        queue_pulse(16'd8000, 1'b0, 1'b1);
        queue_pulse(16'hFFFF, 1'b0, 1'b1);
        queue_pulse(16'd0, 1'b0, 1'b1);
        queue_pulse(16'hFFFF, 1'b0, 1'b1);
        queue_pulse(16'd0, 1'b0, 1'b1);
        queue_pulse(16'd0, 1'b0, 1'b1);
        queue_pulse(16'd8000, 1'b0, 1'b1);
        queue_pulse(16'd4000, 1'b0, 1'b1);
        queue_pulse(16'd1000, 1'b0, 1'b1);
        queue_pulse(16'd1000, 1'b0, 1'b1);
        queue_pulse(16'd0, 1'b1, 1'b1);
        wait_drained();

        // Counts shrink in the middle of a packet: the bit position is already
        // past the new bit count, and the next gap brings the copies seen up to the new total.
        queue_pulse(16'd4000, 1'b0, 1'b1);
        queue_pulse(16'd1000, 1'b0, 1'b1);
        wait_drained();
        write_reg(CFG_BITS_PER_COPY, 16'd1);
        queue_pulse(16'd5000, 1'b0, 1'b1);
        wait_drained();
        write_reg(CFG_COPY_COUNT, 16'd1);
        queue_pulse(16'd8000, 1'b0, 1'b1);
        wait_drained();

        // Random packets. Sender idles lightly, receiver heavily.
        set_config(1000, 4000, 8000, 3, 8);
        run_phase(130);
        set_config(0, 0, 0, 0, 0);
        run_phase(80);
        set_config(65535, 65535, 65535, 15, 2);
        run_phase(90);

        // Sender idles heavily, receiver lightly.
        send_idle_pct = 69;
        recv_idle_pct = 16;
        set_config(300, 1500, 2500, 1, 127);
        run_phase(130);
        set_config(500, 2000, 3000, 2, 5);
        run_phase(100);
        set_config($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(15), $urandom_range(16));
        run_phase(100);

        // No idling on either side; the long output hold-off happens here with
        // three-pulse packets so results pile up quickly.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(15), $urandom_range(16));
        run_phase(100);
        set_config(100, 200, 300, 1, 1);
        hold_armed = 1'b1;
        run_phase(80);
        set_config(800, 3000, 6000, 6, 12);
        run_phase(100);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
